// ===== rtl/msf_pkg.sv =====
package msf_pkg;

  // Operation codes carried on the request channel.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_PUSH = 2'd0;
  localparam opcode_t OP_POP  = 2'd1;
  localparam opcode_t OP_DROP = 2'd2;

  localparam int WORDS       = 4;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = 3;
  localparam int SRC_W       = 3;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [SRC_W-1:0]   src_t;

  // One stored packet: word count and up to four words.
  typedef struct packed {
    count_t            count;
    logic [WORDS-1:0][WORD_W-1:0] words;
  } entry_t;

endpackage

// ===== rtl/msf_req_if.sv =====
interface msf_req_if import msf_pkg::*; ();
  logic    valid;
  logic    ready;
  opcode_t operation;
  src_t    src_id;
  count_t  in_count;
  word_t   in_word0;
  word_t   in_word1;
  word_t   in_word2;
  word_t   in_word3;

  modport source (
    output valid, operation, src_id, in_count, in_word0, in_word1, in_word2, in_word3,
    input  ready
  );
  modport sink (
    input  valid, operation, src_id, in_count, in_word0, in_word1, in_word2, in_word3,
    output ready
  );
endinterface

// ===== rtl/msf_rsp_if.sv =====
interface msf_rsp_if import msf_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   ok;
  count_t pop_count;
  word_t  out_word0;
  word_t  out_word1;
  word_t  out_word2;
  word_t  out_word3;
  word_t  drop_total;

  modport source (
    output valid, ok, pop_count, out_word0, out_word1, out_word2, out_word3, drop_total,
    input  ready
  );
  modport sink (
    input  valid, ok, pop_count, out_word0, out_word1, out_word2, out_word3, drop_total,
    output ready
  );
endinterface

// ===== rtl/multi_source_packet_fifo_unit.sv =====
// Multi-source packet FIFO. The block keeps one ring-buffer queue of QUEUE_DEPTH packets
// for each of SOURCES sources; a packet is one to four 32-bit words and its word count.
// Each request beat (push, pop or count-drop) gives exactly one response beat, in order.
// All packets live in one synchronous memory of SOURCES * QUEUE_DEPTH entries, 131 bits
// wide, with one write port and one read port; pointers, fill levels and the 32-bit
// wrapping drop counters are kept in flip-flops and are cleared by reset. The memory
// contents are not cleared, since only entries that were pushed can ever be popped.
// Throughput is one request beat per cycle while the response side keeps up. The response
// passes through the pending stage and the output register: the memory read and the
// pending stage load at the accepting edge, and the output register loads when the pending
// stage advances. A pop of a packet pushed in the cycle before reads the new data, because
// the write completes at the edge that takes the push, ahead of the read. When the response side stalls,
// one finished response waits in the output register and one more request is held in
// the pending stage before the request side is back-pressured.
module multi_source_packet_fifo_unit
  import msf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int SOURCES     = 4
) (
  input  logic     clk,
  input  logic     rst,
  msf_req_if.sink   req,
  msf_rsp_if.source rsp
);

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SIW   = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int DEPTH = SOURCES * QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  // Per-source control state.
  logic [PW-1:0] read_pointer  [SOURCES];
  logic [PW-1:0] write_pointer [SOURCES];
  logic [FW-1:0] fill_level    [SOURCES];
  word_t         drop_counter  [SOURCES];

  // Packet storage.
  entry_t mem [DEPTH];
  entry_t rd_entry;

  // Pending stage: the request whose memory read is in flight.
  logic  pend_valid;
  logic  pend_ok;
  logic  pend_pop;
  word_t pend_total;

  logic accept;
  logic pend_advance;

  // Decode of the request beat.
  logic           src_valid;
  logic [SIW-1:0] src_idx;
  logic           cnt_valid;
  logic           is_full;
  logic           is_empty;
  logic           do_push;
  logic           do_pop;
  logic           drop_inc;
  logic           req_ok;
  word_t          drop_next;
  word_t          total_next;
  logic [AW-1:0]  base_addr;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  entry_t         wr_entry;

  // The pending stage moves to the output register when that register is free or
  // being emptied in this cycle; a new request enters behind it at the same edge.
  assign pend_advance = pend_valid && (!rsp.valid || rsp.ready);
  assign req.ready    = !pend_valid || pend_advance;
  assign accept       = req.valid && req.ready;

  always_comb begin
    src_valid = (int'(req.src_id) < SOURCES);
    src_idx   = src_valid ? req.src_id[SIW-1:0] : '0;
    cnt_valid = (req.in_count >= count_t'(1)) && (req.in_count <= count_t'(WORDS));
    is_full   = (fill_level[src_idx] == FW'(QUEUE_DEPTH));
    is_empty  = (fill_level[src_idx] == '0);

    do_push  = src_valid && (req.operation == OP_PUSH) && cnt_valid && !is_full;
    do_pop   = src_valid && (req.operation == OP_POP) && !is_empty;
    // A refused push to a full queue counts as a drop, as does an explicit count-drop.
    drop_inc = src_valid && (((req.operation == OP_PUSH) && cnt_valid && is_full) ||
                             (req.operation == OP_DROP));
    req_ok   = do_push || do_pop || (src_valid && (req.operation == OP_DROP));

    drop_next  = drop_counter[src_idx] + word_t'(drop_inc);
    total_next = src_valid ? drop_next : '0;

    base_addr = AW'(int'(src_idx) * QUEUE_DEPTH);
    wr_addr   = base_addr + AW'(write_pointer[src_idx]);
    rd_addr   = base_addr + AW'(read_pointer[src_idx]);

    wr_entry.count    = req.in_count;
    wr_entry.words[0] = req.in_word0;
    wr_entry.words[1] = req.in_word1;
    wr_entry.words[2] = req.in_word2;
    wr_entry.words[3] = req.in_word3;
  end

  // Control state update at the accepting edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SOURCES; s++) begin
        read_pointer[s]  <= '0;
        write_pointer[s] <= '0;
        fill_level[s]    <= '0;
        drop_counter[s]  <= '0;
      end
    end else if (accept) begin
      if (do_push) begin
        write_pointer[src_idx] <= (write_pointer[src_idx] == PW'(QUEUE_DEPTH - 1)) ?
                                  '0 : write_pointer[src_idx] + PW'(1);
        fill_level[src_idx]    <= fill_level[src_idx] + FW'(1);
      end
      if (do_pop) begin
        read_pointer[src_idx] <= (read_pointer[src_idx] == PW'(QUEUE_DEPTH - 1)) ?
                                 '0 : read_pointer[src_idx] + PW'(1);
        fill_level[src_idx]   <= fill_level[src_idx] - FW'(1);
      end
      if (drop_inc) begin
        drop_counter[src_idx] <= drop_next;
      end
    end
  end

  // Packet memory: one write port, one registered read port. The read data register
  // only loads on a pop, so it holds while the pending stage is stalled.
  always_ff @(posedge clk) begin
    if (accept && do_push) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && do_pop) begin
      rd_entry <= mem[rd_addr];
    end
  end

  // Pending stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept) begin
      pend_valid <= 1'b1;
    end else if (pend_advance) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_ok    <= req_ok;
      pend_pop   <= do_pop;
      pend_total <= total_next;
    end
  end

  // Output register. Words at or beyond the packet's count read as zero, and a
  // response that popped nothing carries a zero count and zero words.
  logic [WORDS-1:0][WORD_W-1:0] masked_words;
  count_t                       out_cnt;

  always_comb begin
    out_cnt = pend_pop ? rd_entry.count : '0;
    for (int i = 0; i < WORDS; i++) begin
      masked_words[i] = (count_t'(i) < out_cnt) ? rd_entry.words[i] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (pend_advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_advance) begin
      rsp.ok         <= pend_ok;
      rsp.pop_count  <= out_cnt;
      rsp.out_word0  <= masked_words[0];
      rsp.out_word1  <= masked_words[1];
      rsp.out_word2  <= masked_words[2];
      rsp.out_word3  <= masked_words[3];
      rsp.drop_total <= pend_total;
    end
  end

endmodule
